// ===== rtl/scev_pkg.sv =====
// Shared types, constants and the FNV-1a 64 step for the shader cache entry validator.
// Used by every module under rtl; depends on nothing.
package scev_pkg;

   localparam int unsigned HdrBytes = 40;
   localparam int unsigned MinWords = 5;

   localparam logic [31:0] HdrMagic   = 32'h3256_5053;
   localparam logic [31:0] HdrVersion = 32'd2;
   localparam logic [31:0] SpvMagic   = 32'h0723_0203;
   localparam logic [63:0] FnvBasis   = 64'hCBF2_9CE4_8422_2325;
   localparam logic [31:0] PosMax     = 32'hFFFF_FFFF;
   localparam logic [31:0] CountMax   = 32'hFFFF_FFFF;
   localparam logic [63:0] MaxBytesReset = 64'd67108864;

   // Configuration register indexes.
   localparam logic [1:0] CsrStageCode      = 2'd0;
   localparam logic [1:0] CsrContractLength = 2'd1;
   localparam logic [1:0] CsrSourceLength   = 2'd2;
   localparam logic [1:0] CsrMaxEntryBytes  = 2'd3;

   // Verdict codes; the first failing check wins, in this order.
   localparam logic [2:0] VerdictOk     = 3'd0;
   localparam logic [2:0] VerdictSize   = 3'd1;
   localparam logic [2:0] VerdictHeader = 3'd2;
   localparam logic [2:0] VerdictLength = 3'd3;
   localparam logic [2:0] VerdictHash   = 3'd4;
   localparam logic [2:0] VerdictPrefix = 3'd5;
   localparam logic [2:0] VerdictSpirv  = 3'd6;

   // Per-byte control that the top level hands to the hash and word units.
   typedef struct packed {
      logic       advance;   // the registered item is consumed this cycle
      logic       clear;     // it is the last byte of the file
      logic       payload;   // it lies in the payload
      logic       in_prefix; // it lies in the contract or source prefix
      logic [1:0] lane;      // byte lane within the current SPIR-V word
   } step_ctl_type;

   // SPIR-V walk result, valid for the state after the current byte.
   typedef struct packed {
      logic malformed;
      logic too_few_words;
      logic overrun;
   } walk_status_type;

   // One FNV-1a 64 step; the prime 2^40 + 0x1b3 turns into shifts and adds.
   function automatic logic [63:0] fnv_step(input logic [63:0] hash, input logic [7:0] data);
      logic [63:0] x;
      begin
         x = hash ^ {56'd0, data};
         fnv_step = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
      end
   endfunction

endpackage

// ===== rtl/scev_fnv_hash.sv =====
// FNV-1a 64 running hash over the payload bytes of one cache entry.
// Depends on scev_pkg for the control struct, the basis and the step function.
module scev_fnv_hash (
   input  logic                 clock,
   input  logic                 reset,
   input  scev_pkg::step_ctl_type ctl,
   input  logic [7:0]           data_byte,
   output logic [63:0]          hash_next
);
   import scev_pkg::*;

   logic [63:0] hash_ff;
   logic [63:0] hash_in;

   always_comb begin
      hash_next = ctl.payload ? fnv_step(hash_ff, data_byte) : hash_ff;
      hash_in   = ctl.clear ? FnvBasis : hash_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FnvBasis;
      end else if (ctl.advance) begin
         hash_ff <= hash_in;
      end
   end

endmodule

// ===== rtl/scev_spirv_walk.sv =====
// Assembles little-endian SPIR-V words from the payload and walks the instruction lengths.
// Depends on scev_pkg for the control and status structs and the SPIR-V constants.
module scev_spirv_walk (
   input  logic                    clock,
   input  logic                    reset,
   input  scev_pkg::step_ctl_type  ctl,
   input  logic [7:0]              data_byte,
   output scev_pkg::walk_status_type status
);
   import scev_pkg::*;

   logic [23:0] asm_ff, asm_in;
   logic [31:0] word_idx_ff, word_idx_in;
   logic [31:0] next_instr_ff, next_instr_in;
   logic        malformed_ff, malformed_in;
   logic [31:0] word;
   logic [15:0] instr_len;

   always_comb begin
      word          = {data_byte, asm_ff};
      instr_len     = word[31:16];
      asm_in        = asm_ff;
      word_idx_in   = word_idx_ff;
      next_instr_in = next_instr_ff;
      malformed_in  = malformed_ff;
      if (ctl.payload && !ctl.in_prefix) begin
         case (ctl.lane)
            2'd0: asm_in[7:0]   = data_byte;
            2'd1: asm_in[15:8]  = data_byte;
            2'd2: asm_in[23:16] = data_byte;
            default: begin
               asm_in = '0;
               if ((word_idx_ff == 32'd0 && word != SpvMagic) ||
                   (word_idx_ff == 32'd3 && word == 32'd0) ||
                   (word_idx_ff == 32'd4 && word != 32'd0)) begin
                  malformed_in = 1'b1;
               end
               // Only the word that opens an instruction carries a length.
               if (!malformed_ff && word_idx_ff >= 32'(MinWords) &&
                   word_idx_ff == next_instr_ff) begin
                  if (instr_len == 16'd0) begin
                     malformed_in = 1'b1;
                  end else begin
                     next_instr_in = next_instr_ff + {16'd0, instr_len};
                  end
               end
               word_idx_in = word_idx_ff + 32'd1;
            end
         endcase
      end
      status.malformed     = malformed_in;
      status.too_few_words = word_idx_in < 32'(MinWords);
      status.overrun       = next_instr_in > word_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_ff        <= '0;
         word_idx_ff   <= '0;
         next_instr_ff <= 32'(MinWords);
         malformed_ff  <= 1'b0;
      end else if (ctl.advance) begin
         if (ctl.clear) begin
            asm_ff        <= '0;
            word_idx_ff   <= '0;
            next_instr_ff <= 32'(MinWords);
            malformed_ff  <= 1'b0;
         end else begin
            asm_ff        <= asm_in;
            word_idx_ff   <= word_idx_in;
            next_instr_ff <= next_instr_in;
            malformed_ff  <= malformed_in;
         end
      end
   end

endmodule

// ===== rtl/shader_cache_entry_validator_unit.sv =====
// Shader cache entry validator: takes a cache entry file one byte per item and gives one
// verdict item when the byte marked last has been taken. The block sustains one byte per
// clock while no last byte is held: an accepted item sits in an input register and is consumed
// from there, where the hash, prefix, SPIR-V and header checks all finish; the verdict is
// registered as its last byte is consumed. The only stall comes from the result register: a
// last byte waits while a previous verdict has not been taken. No clearing pass follows reset.
module shader_cache_entry_validator_unit (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] file_byte, [15:8] expected_byte
   input  logic        req_tlast,  // last_byte
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [2:0] verdict_code, [34:3] rejected_total, [39:35] zero
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import scev_pkg::*;

   // Configuration registers.
   logic [31:0] stage_code_ff;
   logic [23:0] contract_len_ff;
   logic [23:0] source_len_ff;
   logic [31:0] max_bytes_ff;

   // Input register.
   logic        in_valid_ff;
   logic [7:0]  in_file_ff;
   logic [7:0]  in_expect_ff;
   logic        in_last_ff;

   // Per-file state.
   logic [31:0] pos_ff;
   logic [HdrBytes-1:0][7:0] header_ff;
   logic [HdrBytes-1:0][7:0] header_in;
   logic        prefix_bad_ff, prefix_bad_in;
   logic [31:0] rejected_ff, rejected_in;

   // Result register.
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;

   logic            advance;
   step_ctl_type    ctl;
   logic [31:0]     offset;
   logic [24:0]     prefix_len;
   logic [63:0]     hash_next;
   walk_status_type walk;
   logic [31:0]     plen;
   logic [34:0]     len_sum;
   logic [31:0]     word_count;
   logic [2:0]      verdict;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_code_ff   <= '0;
         contract_len_ff <= '0;
         source_len_ff   <= '0;
         max_bytes_ff    <= MaxBytesReset[31:0];
      end else if (csr_valid) begin
         case (csr_index)
            CsrStageCode:      stage_code_ff   <= csr_data;
            CsrContractLength: contract_len_ff <= csr_data[23:0];
            CsrSourceLength:   source_len_ff   <= csr_data[23:0];
            CsrMaxEntryBytes:  max_bytes_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Position decode for the registered byte.
   always_comb begin
      offset        = pos_ff - 32'(HdrBytes);
      prefix_len    = {1'b0, contract_len_ff} + {1'b0, source_len_ff};
      ctl.advance   = advance;
      ctl.clear     = in_last_ff;
      ctl.payload   = pos_ff >= 32'(HdrBytes) && pos_ff != PosMax;
      ctl.in_prefix = offset < {7'd0, prefix_len};
      ctl.lane      = offset[1:0] - prefix_len[1:0];
   end

   always_comb begin
      header_in = header_ff;
      if (pos_ff < 32'(HdrBytes)) begin
         header_in[pos_ff[5:0]] = in_file_ff;
      end
      prefix_bad_in = prefix_bad_ff ||
                      (ctl.payload && ctl.in_prefix && in_file_ff != in_expect_ff);
   end

   scev_fnv_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .data_byte (in_file_ff),
      .hash_next (hash_next)
   );

   scev_spirv_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .data_byte (in_file_ff),
      .status    (walk)
   );

   // Verdict on the state as it stands after the registered byte.
   always_comb begin
      word_count = header_in[23:20];
      plen       = pos_ff - 32'(HdrBytes - 1);
      len_sum    = 35'(contract_len_ff) + 35'(source_len_ff) + {1'b0, word_count, 2'b00};
      if (pos_ff < 32'(HdrBytes - 1) || pos_ff >= max_bytes_ff) begin
         verdict = VerdictSize;
      end else if (header_in[3:0] != HdrMagic || header_in[7:4] != HdrVersion ||
                   header_in[11:8] != stage_code_ff ||
                   header_in[15:12] != {8'd0, contract_len_ff} ||
                   header_in[19:16] != {8'd0, source_len_ff} ||
                   word_count < 32'(MinWords)) begin
         verdict = VerdictHeader;
      end else if (header_in[31:24] != {32'd0, plen} || len_sum != {3'd0, plen}) begin
         verdict = VerdictLength;
      end else if (header_in[39:32] != hash_next) begin
         verdict = VerdictHash;
      end else if (prefix_bad_in) begin
         verdict = VerdictPrefix;
      end else if (walk.malformed || walk.too_few_words || walk.overrun) begin
         verdict = VerdictSpirv;
      end else begin
         verdict = VerdictOk;
      end
      rejected_in = rejected_ff;
      if (verdict != VerdictOk && rejected_ff != CountMax) begin
         rejected_in = rejected_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_file_ff   <= req_tdata[7:0];
         in_expect_ff <= req_tdata[15:8];
         in_last_ff   <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         header_ff <= header_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         prefix_bad_ff <= 1'b0;
         rejected_ff   <= '0;
      end else if (advance) begin
         if (in_last_ff) begin
            pos_ff        <= '0;
            prefix_bad_ff <= 1'b0;
            rejected_ff   <= rejected_in;
         end else begin
            if (pos_ff != PosMax) begin
               pos_ff <= pos_ff + 32'd1;
            end
            prefix_bad_ff <= prefix_bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_data_ff <= {5'd0, rejected_in, verdict};
      end
   end

   a_result_from_last : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("result appeared without a last item being consumed");

   a_pos_restarts : assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> pos_ff == 32'd0)
      else $error("byte position did not restart after a last item");

   a_rejects_monotonic : assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> rejected_ff >= $past(rejected_ff))
      else $error("reject count went down");

   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("pending result lost while stalled");

endmodule

// ===== tb/sv/scev_checker.sv =====
`timescale 1ns / 100ps
// Checker for the shader cache entry validator: watches the byte, verdict and register channels,
// predicts each verdict item and compares it field by field. Depends on rtl/scev_pkg.sv.
module scev_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          mismatch_count,
   output int          verdicts_pending,
   output int          verdicts_checked,
   output logic [6:0]  verdict_kinds
);
   import scev_pkg::*;

   localparam logic [63:0] FnvPrime = 64'h0000_0100_0000_01B3;

   typedef struct packed {
      logic [2:0]  code;
      logic [31:0] rejected;
   } entry_verdict_type;

   // Register copies.
   logic [31:0] cfg_stage;
   logic [23:0] cfg_contract;
   logic [23:0] cfg_source;
   logic [31:0] cfg_max_bytes;

   // Per-entry state.
   logic [31:0] file_pos;
   logic [7:0]  head_bytes [HdrBytes];
   logic [63:0] fnv;
   logic        prefix_bad;
   logic [31:0] word_acc;
   logic [31:0] words_seen;
   logic [31:0] next_op_word;
   logic        spv_bad;
   logic [31:0] rejects;

   entry_verdict_type verdicts_owed [$];
   int          errors = 0;
   int          checked = 0;
   logic [6:0]  kinds_seen = '0;

   task automatic flag_mismatch(input string what, input logic [39:0] got,
                                input logic [39:0] want);
      $display("%0t: verdict %0d: %s is 0x%0h, expected 0x%0h", $time, checked, what, got, want);
      errors++;
   endtask

   function automatic void clear_entry();
      file_pos     = '0;
      fnv          = FnvBasis;
      prefix_bad   = 1'b0;
      word_acc     = '0;
      words_seen   = '0;
      next_op_word = MinWords;
      spv_bad      = 1'b0;
   endfunction

   // Little-endian header field, len bytes starting at byte offset at.
   function automatic logic [63:0] head_field(input int at, input int len);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < len; i++) begin
         v |= {56'd0, head_bytes[(at + i) % HdrBytes]} << (8 * i);
      end
      return v;
   endfunction

   // SPIR-V header words, then the instruction chain by word counts.
   function automatic void absorb_word(input logic [31:0] w);
      if (words_seen == 0 && w != SpvMagic) spv_bad = 1'b1;
      if (words_seen == 3 && w == 0) spv_bad = 1'b1;
      if (words_seen == 4 && w != 0) spv_bad = 1'b1;
      if (!spv_bad && words_seen >= MinWords && words_seen == next_op_word) begin
         if (w[31:16] == 16'd0) spv_bad = 1'b1;
         else next_op_word = next_op_word + {16'd0, w[31:16]};
      end
      words_seen = words_seen + 1;
   endfunction

   function automatic logic [2:0] judge_entry(input logic [63:0] size);
      logic [63:0] plen;
      logic [63:0] count;
      if (size < HdrBytes || size > {32'd0, cfg_max_bytes}) return VerdictSize;
      plen  = size - HdrBytes;
      count = head_field(20, 4);
      if (head_field(0, 4) != HdrMagic || head_field(4, 4) != HdrVersion ||
          head_field(8, 4) != cfg_stage || head_field(12, 4) != cfg_contract ||
          head_field(16, 4) != cfg_source || count < MinWords) return VerdictHeader;
      if (head_field(24, 8) != plen ||
          {40'd0, cfg_contract} + {40'd0, cfg_source} + count * 4 != plen) return VerdictLength;
      if (head_field(32, 8) != fnv) return VerdictHash;
      if (prefix_bad) return VerdictPrefix;
      if (spv_bad || words_seen < MinWords || next_op_word > words_seen) return VerdictSpirv;
      return VerdictOk;
   endfunction

   function automatic void take_byte(input logic [7:0] b, input logic [7:0] e,
                                     input logic last);
      logic [31:0] at;
      logic [63:0] ofs;
      logic [63:0] pre;
      logic [63:0] into_words;
      logic [1:0]  lane;
      logic [2:0]  code;
      entry_verdict_type owed_now;
      at = file_pos;
      if (at < HdrBytes) begin
         head_bytes[at] = b;
      end else if (at != PosMax) begin
         ofs = {32'd0, at} - HdrBytes;
         pre = {40'd0, cfg_contract} + {40'd0, cfg_source};
         fnv = (fnv ^ {56'd0, b}) * FnvPrime;
         if (ofs < pre) begin
            if (b != e) prefix_bad = 1'b1;
         end else begin
            into_words = ofs - pre;
            lane = into_words[1:0];
            word_acc |= {24'd0, b} << (8 * lane);
            if (lane == 2'd3) begin
               absorb_word(word_acc);
               word_acc = '0;
            end
         end
      end
      if (file_pos != PosMax) file_pos = file_pos + 1;
      if (last) begin
         code = judge_entry({32'd0, at} + 64'd1);
         if (code != VerdictOk && rejects != CountMax) rejects = rejects + 1;
         owed_now.code     = code;
         owed_now.rejected = rejects;
         verdicts_owed     = {verdicts_owed, owed_now};
         clear_entry();
      end
   endfunction

   always @(posedge clock) begin : watch
      entry_verdict_type owed;
      if (reset) begin
         cfg_stage     = '0;
         cfg_contract  = '0;
         cfg_source    = '0;
         cfg_max_bytes = MaxBytesReset[31:0];
         rejects       = '0;
         for (int i = 0; i < HdrBytes; i++) head_bytes[i] = '0;
         verdicts_owed.delete();
         clear_entry();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrStageCode:      cfg_stage = csr_data;
               CsrContractLength: cfg_contract = csr_data[23:0];
               CsrSourceLength:   cfg_source = csr_data[23:0];
               CsrMaxEntryBytes:  cfg_max_bytes = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_owed.size() == 0) begin
               flag_mismatch("verdict item with none outstanding", rsp_tdata, '0);
            end else begin
               owed = verdicts_owed.pop_front();
               kinds_seen[owed.code] = 1'b1;
               if (rsp_tdata[2:0] !== owed.code)
                  flag_mismatch("verdict_code", 40'(rsp_tdata[2:0]), 40'(owed.code));
               if (rsp_tdata[34:3] !== owed.rejected)
                  flag_mismatch("rejected_total", 40'(rsp_tdata[34:3]), 40'(owed.rejected));
               if (rsp_tdata[39:35] !== 5'd0)
                  flag_mismatch("padding bits", 40'(rsp_tdata[39:35]), '0);
               checked++;
            end
         end
         if (req_tvalid && req_tready) take_byte(req_tdata[7:0], req_tdata[15:8], req_tlast);
      end
      mismatch_count   <= errors;
      verdicts_pending <= verdicts_owed.size();
      verdicts_checked <= checked;
      verdict_kinds    <= kinds_seen;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the shader cache entry validator testbench: builds cache entry files, clean and
// damaged, drives them byte by byte and gives the verdict. Depends on rtl/ and scev_checker.
module tb_top;
   import scev_pkg::*;

   localparam int          IdleLimit   = 2000;
   localparam int          ItemTarget  = 1850;
   localparam int          EntryTarget = 16;
   localparam logic [63:0] FnvPrime    = 64'h0000_0100_0000_01B3;

   // How an entry file is built; everything between clean and resize damages one thing.
   typedef enum int {
      EntryClean,
      EntryMagic,
      EntryVersion,
      EntryStage,
      EntryContract,
      EntrySource,
      EntryFewWords,
      EntryWordCount,
      EntryPayloadLen,
      EntryHash,
      EntryPrefix,
      EntrySpvMagic,
      EntryIdBound,
      EntrySchema,
      EntryZeroOp,
      EntryOverrun,
      EntryTruncate,
      EntryResize,
      EntryNoise
   } entry_kind_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   int          mismatch_count;
   int          verdicts_pending;
   int          verdicts_checked;
   logic [6:0]  verdict_kinds;

   // Register values as last written.
   logic [31:0] cur_stage = '0;
   logic [23:0] cur_contract = '0;
   logic [23:0] cur_source = '0;
   logic [31:0] cur_max = MaxBytesReset[31:0];

   int          items_sent = 0;
   int          entries_sent = 0;
   int          settings_used = 0;
   bit          req_calm = 1'b0;
   int          idle_cycles = 0;
   int          rsp_hold = 0;
   int          rsp_calm_left = 0;

   shader_cache_entry_validator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   scev_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .verdicts_pending (verdicts_pending),
      .verdicts_checked (verdicts_checked),
      .verdict_kinds    (verdict_kinds)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Result side: mostly ready, short stalls, a few long ones, and calm stretches.
   always @(posedge clock) begin : rsp_pace
      int r;
      r = $urandom_range(0, 99);
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_calm_left > 0) begin
         rsp_calm_left <= rsp_calm_left - 1;
         rsp_tready    <= 1'b1;
      end else if (r < 3) begin
         rsp_calm_left <= $urandom_range(30, 200);
         rsp_tready    <= 1'b1;
      end else if (r < 65) begin
         rsp_tready <= 1'b1;
      end else if (r < 96) begin
         rsp_hold   <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_hold   <= $urandom_range(10, 60);
         rsp_tready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Watchdog: no item moved for %0d cycles.", IdleLimit);
         $display("shader_cache_entry_validator_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int req_gap();
      int r;
      r = $urandom_range(0, 99);
      if (req_calm) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic [7:0] e, input logic last);
      int gap;
      gap = req_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {e, b};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write of a batch.
   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Stops driving and waits until every verdict has come back and the block has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input int phase);
      case (phase)
         0: begin
            cur_stage    = '0;
            cur_contract = '0;
            cur_source   = '0;
            cur_max      = HdrBytes;
         end
         1: begin
            cur_stage    = '1;
            cur_contract = '1;
            cur_source   = '1;
            cur_max      = '1;
         end
         default: begin
            case ($urandom_range(0, 3))
               0: cur_stage = '0;
               1: cur_stage = '1;
               default: cur_stage = $urandom;
            endcase
            cur_contract = 24'($urandom_range(0, 6));
            cur_source   = 24'($urandom_range(0, 6));
            case ($urandom_range(0, 4))
               0: cur_max = '1;
               1: cur_max = MaxBytesReset[31:0];
               2: cur_max = $urandom_range(40, 100);
               3: cur_max = HdrBytes;
               default: cur_max = $urandom_range(100, 5000);
            endcase
         end
      endcase
      // The upper byte of the length writes is don't-care and gets random bits.
      write_reg(CsrStageCode, cur_stage);
      write_reg(CsrContractLength, {8'($urandom), cur_contract});
      write_reg(CsrSourceLength, {8'($urandom), cur_source});
      write_reg(CsrMaxEntryBytes, cur_max);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic entry_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return EntryClean;
      if (r < 85) return entry_kind_type'($urandom_range(EntryMagic, EntryResize));
      return EntryNoise;
   endfunction

   task automatic send_entry(input entry_kind_type kind);
      logic [319:0] head;
      logic [7:0]   body [$];
      logic [7:0]   want [$];
      logic [31:0]  words [$];
      int           op_starts [$];
      logic [31:0]  w;
      logic [63:0]  hash;
      int           prefix_len;
      int           nwords;
      int           left;
      int           span;
      int           total;
      int           k;
      req_calm = ($urandom_range(0, 3) == 0);
      entries_sent++;
      if (kind == EntryNoise) begin
         total = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 39) : $urandom_range(40, 90);
         for (int i = 0; i < total; i++) send_byte(8'($urandom), 8'($urandom), i == total - 1);
         return;
      end

      // A prefix too long to send is cut short; such an entry fails the length sum.
      prefix_len = int'(cur_contract) + int'(cur_source);
      if (prefix_len > 48) prefix_len = $urandom_range(0, 8);
      for (int i = 0; i < prefix_len; i++) begin
         body = {body, 8'($urandom)};
         want = {want, body[i]};
      end

      nwords = 5 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6));
      w = $urandom;
      if (w == 0) w = 32'd1;
      words = {words, SpvMagic};
      words = {words, 32'($urandom)};
      words = {words, 32'($urandom)};
      words = {words, w};
      words = {words, 32'd0};
      left = nwords - 5;
      while (left > 0) begin
         span = $urandom_range(1, (left > 4) ? 4 : left);
         op_starts = {op_starts, words.size()};
         w = $urandom;
         w[31:16] = 16'(span);
         words = {words, w};
         repeat (span - 1) words = {words, 32'($urandom)};
         left -= span;
      end

      case (kind)
         EntrySpvMagic: words[0] = words[0] ^ (32'd1 << $urandom_range(0, 31));
         EntryIdBound:  words[3] = 32'd0;
         EntrySchema: begin
            w = $urandom;
            if (w == 0) w = 32'h8000_0000;
            words[4] = w;
         end
         EntryZeroOp: if (op_starts.size() > 0) begin
            k = op_starts[$urandom_range(0, op_starts.size() - 1)];
            w = words[k];
            w[31:16] = 16'd0;
            words[k] = w;
         end
         EntryOverrun: if (op_starts.size() > 0) begin
            k = op_starts[op_starts.size() - 1];
            w = words[k];
            w[31:16] = 16'(nwords - k + int'($urandom_range(1, 3)));
            words[k] = w;
         end
         default: ;
      endcase

      foreach (words[i]) begin
         for (int j = 0; j < 4; j++) begin
            body = {body, words[i][8 * j +: 8]};
            want = {want, 8'($urandom)};
         end
      end
      if (kind == EntryPrefix && prefix_len > 0) begin
         k = $urandom_range(0, prefix_len - 1);
         want[k] = want[k] ^ 8'($urandom_range(1, 255));
      end

      hash = FnvBasis;
      foreach (body[i]) hash = (hash ^ {56'd0, body[i]}) * FnvPrime;
      head = {hash, 64'(body.size()), 32'(nwords), 8'd0, cur_source, 8'd0, cur_contract,
              cur_stage, HdrVersion, HdrMagic};

      case (kind)
         EntryMagic:      head[$urandom_range(0, 31)] ^= 1'b1;
         EntryVersion:    head[32 + $urandom_range(0, 31)] ^= 1'b1;
         EntryStage:      head[64 + $urandom_range(0, 31)] ^= 1'b1;
         EntryContract:   head[96 + $urandom_range(0, 31)] ^= 1'b1;
         EntrySource:     head[128 + $urandom_range(0, 31)] ^= 1'b1;
         EntryFewWords:   head[191:160] = $urandom_range(0, 4);
         EntryWordCount:  head[191:160] = head[191:160] + 32'd1;
         EntryPayloadLen: head[192 + $urandom_range(0, 63)] ^= 1'b1;
         EntryHash:       head[256 + $urandom_range(0, 63)] ^= 1'b1;
         default: ;
      endcase

      total = HdrBytes + body.size();
      if (kind == EntryTruncate) begin
         total = ($urandom_range(0, 1) == 0) ? HdrBytes : $urandom_range(HdrBytes, total - 1);
      end else if (kind == EntryResize) begin
         repeat ($urandom_range(1, 3)) begin
            body = {body, 8'($urandom)};
            want = {want, 8'($urandom)};
         end
         total = HdrBytes + body.size();
      end

      for (int i = 0; i < total; i++) begin
         if (i < HdrBytes) send_byte(head[8 * i +: 8], 8'($urandom), i == total - 1);
         else send_byte(body[i - HdrBytes], want[i - HdrBytes], i == total - 1);
      end
   endtask

   initial begin : stimulus
      int phase;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Short files under the reset settings, all-ones and all-zeros bytes.
      send_byte(8'hFF, 8'h00, 1'b1);
      entries_sent++;
      for (int i = 0; i < 20; i++) begin
         send_byte((i % 2 == 0) ? 8'h00 : 8'hFF, (i % 2 == 0) ? 8'hFF : 8'h00, i == 19);
      end
      entries_sent++;
      drain();

      phase = 0;
      while (items_sent < ItemTarget || entries_sent < EntryTarget) begin
         apply_setting(phase);
         repeat ((phase < 2) ? 4 : $urandom_range(3, 8)) send_entry(pick_kind());
         drain();
         phase++;
      end

      $display("Drove %0d bytes in %0d entry files under %0d register settings.",
               items_sent, entries_sent, settings_used + 1);
      $display("Checked %0d verdict items; verdict codes seen, one bit per code: %b",
               verdicts_checked, verdict_kinds);
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("shader_cache_entry_validator_unit test passed");
      end else begin
         $display("shader_cache_entry_validator_unit test failed");
      end
      $finish;
   end

endmodule
